@@ design/wbps_pkg.sv @@
// Shared types and constants for the wildcard byte pattern scanner.
`default_nettype none
package wbps_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int OFFSET_BITS       = 32;
  localparam int WIN_DEPTH         = MAX_PATTERN_BYTES - 1;
  localparam int ADDR_BITS         = 48;
  localparam int LEN_BITS          = 5;
  localparam int IDX_BITS          = 4;
  localparam int APB_ADDR_BITS     = 6;
  localparam int APB_DATA_BITS     = 64;
  localparam int OUT_DATA_BITS     = 80;

  typedef enum logic [2:0] {
    REG_PATTERN_FIRST_EIGHT = 3'd0,
    REG_PATTERN_LAST_EIGHT  = 3'd1,
    REG_WILDCARD_MASK       = 3'd2,
    REG_PATTERN_LENGTH      = 3'd3,
    REG_IMAGE_BASE          = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [63:0]            pattern_first_eight;
    logic [63:0]            pattern_last_eight;
    logic [15:0]            wildcard_mask;
    logic [LEN_BITS-1:0]    pattern_length;
    logic [ADDR_BITS-1:0]   image_base;
  } cfg_t;

  typedef struct packed {
    logic                   found;
    logic [OFFSET_BITS-1:0] match_offset;
  } hit_t;

endpackage
`default_nettype wire

@@ design/wbps_cfg_regs.sv @@
// Configuration register file behind the APB-style port.
`default_nettype none
module wbps_cfg_regs
  import wbps_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic      [APB_DATA_BITS-1:0] prdata,
  output logic                          pready,
  output cfg_t                          cfg
);

  reg_index_t index;
  logic       wr_en;

  assign index  = reg_index_t'(paddr[APB_ADDR_BITS-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_first_eight <= '0;
      cfg.pattern_last_eight  <= '0;
      cfg.wildcard_mask       <= '0;
      cfg.pattern_length      <= LEN_BITS'(1);
      cfg.image_base          <= '0;
    end else if (wr_en) begin
      case (index)
        REG_PATTERN_FIRST_EIGHT: cfg.pattern_first_eight <= pwdata;
        REG_PATTERN_LAST_EIGHT:  cfg.pattern_last_eight  <= pwdata;
        REG_WILDCARD_MASK:       cfg.wildcard_mask       <= pwdata[15:0];
        REG_PATTERN_LENGTH:      cfg.pattern_length      <= pwdata[LEN_BITS-1:0];
        REG_IMAGE_BASE:          cfg.image_base          <= pwdata[ADDR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_PATTERN_FIRST_EIGHT: prdata = cfg.pattern_first_eight;
      REG_PATTERN_LAST_EIGHT:  prdata = cfg.pattern_last_eight;
      REG_WILDCARD_MASK:       prdata = APB_DATA_BITS'(cfg.wildcard_mask);
      REG_PATTERN_LENGTH:      prdata = APB_DATA_BITS'(cfg.pattern_length);
      REG_IMAGE_BASE:          prdata = APB_DATA_BITS'(cfg.image_base);
      default:                 prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ design/wbps_match.sv @@
// Byte window, masked comparators and scan state, with the hit register.
`default_nettype none
module wbps_match
  import wbps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] image_byte,
  input  wire logic       end_of_image,
  output logic            hit_valid,
  input  wire logic       hit_ready,
  output hit_t            hit
);

  logic [7:0]             win [WIN_DEPTH];
  logic [7:0]             cand [MAX_PATTERN_BYTES];
  logic [7:0]             pat [MAX_PATTERN_BYTES];
  logic [LEN_BITS-1:0]    fill;
  logic [LEN_BITS-1:0]    fill_next;
  logic [LEN_BITS-1:0]    len;
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic [OFFSET_BITS-1:0] start_offset;
  logic                   already_matched;
  logic                   accept;
  logic                   match;
  logic                   emit;

  assign in_ready = !hit_valid || hit_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (cfg.pattern_length == '0) begin
      len = LEN_BITS'(1);
    end else if (cfg.pattern_length > LEN_BITS'(MAX_PATTERN_BYTES)) begin
      len = LEN_BITS'(MAX_PATTERN_BYTES);
    end else begin
      len = cfg.pattern_length;
    end
  end

  assign fill_next = (fill == LEN_BITS'(MAX_PATTERN_BYTES)) ? fill : fill + LEN_BITS'(1);

  always_comb begin
    cand[0] = image_byte;
    for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
      cand[j] = win[j-1];
    end
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      if (k < 8) begin
        pat[k] = cfg.pattern_first_eight[8*(k%8) +: 8];
      end else begin
        pat[k] = cfg.pattern_last_eight[8*(k%8) +: 8];
      end
    end
  end

  always_comb begin
    logic [LEN_BITS-1:0] back;
    match = !already_matched && (fill_next >= len);
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      back = len - LEN_BITS'(1) - LEN_BITS'(k);
      if ((LEN_BITS'(k) < len) && !cfg.wildcard_mask[k] &&
          (cand[back[IDX_BITS-1:0]] != pat[k])) begin
        match = 1'b0;
      end
    end
  end

  assign start_offset = bytes_seen - OFFSET_BITS'(len - LEN_BITS'(1));
  assign emit         = match || (end_of_image && !already_matched);

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill            <= '0;
      bytes_seen      <= '0;
      already_matched <= 1'b0;
    end else if (accept) begin
      if (end_of_image) begin
        fill            <= '0;
        bytes_seen      <= '0;
        already_matched <= 1'b0;
      end else begin
        fill            <= fill_next;
        bytes_seen      <= bytes_seen + OFFSET_BITS'(1);
        already_matched <= already_matched || match;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !end_of_image) begin
      win[0] <= image_byte;
      for (int i = 1; i < WIN_DEPTH; i++) begin
        win[i] <= win[i-1];
      end
    end
  end

  // hit register
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid <= 1'b0;
    end else if (in_ready) begin
      hit_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit.found        <= match;
      hit.match_offset <= match ? start_offset : '0;
    end
  end

endmodule
`default_nettype wire

@@ design/wbps_result.sv @@
// Address adder and output result register.
`default_nettype none
module wbps_result
  import wbps_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [ADDR_BITS-1:0]     image_base,
  input  wire logic                     hit_valid,
  output logic                          hit_ready,
  input  wire hit_t                     hit,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          found,
  output logic      [OFFSET_BITS-1:0]   match_offset,
  output logic      [ADDR_BITS-1:0]     match_address
);

  logic load;

  assign hit_ready = !out_valid || out_ready;
  assign load      = hit_valid && hit_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (hit_ready) begin
      out_valid <= hit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      found         <= hit.found;
      match_offset  <= hit.match_offset;
      match_address <= hit.found ? image_base + ADDR_BITS'(hit.match_offset) : '0;
    end
  end

endmodule
`default_nettype wire

@@ design/wildcard_byte_pattern_scanner.sv @@
// Top level of the wildcard byte pattern scanner.
// Accepts one image byte per clock cycle while the result path is not stalled; a result
// for an item leaves through a compare register and then an address-add register. The
// rate is set by the sixteen byte comparators that check the shifting window combinationally.
// A scan gives one result: the first match (found set, offset and address), or found clear
// on the item marked tlast when nothing matched. After tlast the block rearms. Registers:
// pattern bytes 0-7 at 0x00, bytes 8-15 at 0x08, wildcard mask at 0x10, pattern length
// at 0x18, image base at 0x20; write them only while no item is in flight.
`default_nettype none
module wildcard_byte_pattern_scanner
  import wbps_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic      [APB_DATA_BITS-1:0] prdata,
  output logic                          pready,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire logic [7:0]               s_axis_tdata,   // image_byte
  input  wire logic                     s_axis_tlast,   // end_of_image
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  output logic      [OUT_DATA_BITS-1:0] m_axis_tdata,   // match_offset, match_address
  output logic                          m_axis_tuser    // found
);

  cfg_t                   cfg;
  hit_t                   hit;
  logic                   hit_valid;
  logic                   hit_ready;
  logic [OFFSET_BITS-1:0] match_offset;
  logic [ADDR_BITS-1:0]   match_address;

  wbps_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wbps_match u_match (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .image_byte   (s_axis_tdata),
    .end_of_image (s_axis_tlast),
    .hit_valid    (hit_valid),
    .hit_ready    (hit_ready),
    .hit          (hit)
  );

  wbps_result u_result (
    .clk           (clk),
    .rst           (rst),
    .image_base    (cfg.image_base),
    .hit_valid     (hit_valid),
    .hit_ready     (hit_ready),
    .hit           (hit),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .found         (m_axis_tuser),
    .match_offset  (match_offset),
    .match_address (match_address)
  );

  assign m_axis_tdata = {match_address, match_offset};

endmodule
`default_nettype wire

@@ design/wbps_checker.sv @@
// Port-level checker for the scanner, bound to the top level.
`default_nettype none
module wbps_checker
  import wbps_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     s_axis_tvalid,
  input wire logic                     s_axis_tready,
  input wire logic                     m_axis_tvalid,
  input wire logic                     m_axis_tready,
  input wire logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  input wire logic                     m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result item changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result item valid after reset");

  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result item without an input item two cycles earlier");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("no-match result carries a non-zero offset or address");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_checker (.*);
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Testbench for the wildcard byte pattern scanner: directed and random images against a predictor.
module tb;
  import wbps_pkg::*;

  localparam int HALF_PERIOD            = 4;
  localparam int RESET_CYCLES           = 12;
  localparam int DRAIN_CYCLES           = 8;
  localparam int HOLD_CYCLES            = 400;
  localparam int CYCLE_LIMIT            = 200000;
  localparam int RANDOM_ITEMS_PER_PHASE = 390;

  typedef struct packed {
    logic                   found;
    logic [OFFSET_BITS-1:0] offset;
    logic [ADDR_BITS-1:0]   address;
  } scan_result_t;

  logic                     clk           = 1'b0;
  logic                     rst           = 1'b1;
  logic                     psel          = 1'b0;
  logic                     penable       = 1'b0;
  logic                     pwrite        = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr         = '0;
  logic [APB_DATA_BITS-1:0] pwdata        = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [7:0]               s_axis_tdata  = '0;    // image_byte
  logic                     s_axis_tlast  = 1'b0;  // end_of_image
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;          // match_offset, match_address
  logic                     m_axis_tuser;          // found

  cfg_t                   cfg;
  logic [7:0]             window [WIN_DEPTH];
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic                   matched;
  int unsigned            fill;
  scan_result_t           pending_results [$];

  int          src_idle_pct   = 0;
  int          sink_stall_pct = 0;
  int unsigned cycle_count    = 0;
  int          fail_count     = 0;
  logic        hold_req       = 1'b0;
  int          hold_left      = 0;

  wildcard_byte_pattern_scanner dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic int unsigned active_length();
    if (cfg.pattern_length == 0) return 1;
    if (cfg.pattern_length > MAX_PATTERN_BYTES) return MAX_PATTERN_BYTES;
    return cfg.pattern_length;
  endfunction

  function automatic logic [7:0] pattern_byte(int unsigned k);
    if (k < 8) return cfg.pattern_first_eight[8*k +: 8];
    return cfg.pattern_last_eight[8*(k-8) +: 8];
  endfunction

  function automatic void clear_scan();
    foreach (window[i]) window[i] = '0;
    bytes_seen = '0;
    matched    = 1'b0;
    fill       = 0;
  endfunction

  function automatic void queue_result(input scan_result_t r);
    pending_results = {pending_results, r};
  endfunction

  function automatic void predict_scan_result(input logic [7:0] cur, input logic is_last);
    int unsigned  len;
    int unsigned  back;
    logic         hit;
    logic [7:0]   b;
    scan_result_t r;
    len = active_length();
    if (fill < MAX_PATTERN_BYTES) fill++;
    hit = !matched && (fill >= len);
    for (int unsigned k = 0; k < len; k++) begin
      back = len - 1 - k;
      b = (back == 0) ? cur : window[back-1];
      if (!cfg.wildcard_mask[k] && b != pattern_byte(k)) hit = 1'b0;
    end
    if (hit) begin
      r.found   = 1'b1;
      r.offset  = bytes_seen - OFFSET_BITS'(len - 1);
      r.address = cfg.image_base + ADDR_BITS'(r.offset);
      queue_result(r);
      matched = 1'b1;
    end else if (is_last && !matched) begin
      r = '0;
      queue_result(r);
    end
    if (is_last) begin
      clear_scan();
    end else begin
      for (int i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = cur;
      bytes_seen++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    scan_result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: found %0b offset %0h", m_axis_tuser,
                 m_axis_tdata[OFFSET_BITS-1:0]);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tuser !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, m_axis_tuser);
            fail_count++;
          end
          if (m_axis_tdata[OFFSET_BITS-1:0] !== want.offset) begin
            $error("match_offset: expected %0h, got %0h", want.offset,
                   m_axis_tdata[OFFSET_BITS-1:0]);
            fail_count++;
          end
          if (m_axis_tdata[OFFSET_BITS +: ADDR_BITS] !== want.address) begin
            $error("match_address: expected %0h, got %0h", want.address,
                   m_axis_tdata[OFFSET_BITS +: ADDR_BITS]);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_scan_result(s_axis_tdata, s_axis_tlast);
    end
  end

  // hold off for a long stretch on request, else stall at random
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_register(input reg_index_t idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_BITS'(idx) << 3;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PATTERN_FIRST_EIGHT: cfg.pattern_first_eight = value;
      REG_PATTERN_LAST_EIGHT:  cfg.pattern_last_eight  = value;
      REG_WILDCARD_MASK:       cfg.wildcard_mask       = value[15:0];
      REG_PATTERN_LENGTH:      cfg.pattern_length      = value[LEN_BITS-1:0];
      REG_IMAGE_BASE:          cfg.image_base          = value[ADDR_BITS-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] value, input logic is_last);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= is_last;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic randomise_config();
    logic [63:0] first;
    logic [63:0] second;
    logic [15:0] mask;
    logic [4:0]  len;
    logic [47:0] base;
    first  = {$urandom, $urandom};
    second = {$urandom, $urandom};
    case ($urandom_range(7))
      0: begin first = '1; second = '1; end
      1: begin first = '0; second = '0; end
      default: ;
    endcase
    case ($urandom_range(9))
      0: len = 5'd0;
      1: len = 5'($urandom_range(31, 17));
      2: len = 5'd16;
      3: len = 5'd1;
      default: len = 5'($urandom_range(16, 1));
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3: mask = '0;
      4:          mask = '1;
      5, 6, 7:    mask = 16'($urandom & $urandom);
      default:    mask = 16'($urandom);
    endcase
    case ($urandom_range(7))
      0: base = '1;
      1: base = '0;
      default: base = 48'({$urandom, $urandom});
    endcase
    write_register(REG_PATTERN_FIRST_EIGHT, first);
    write_register(REG_PATTERN_LAST_EIGHT, second);
    write_register(REG_WILDCARD_MASK, 64'(mask));
    write_register(REG_PATTERN_LENGTH, 64'(len));
    write_register(REG_IMAGE_BASE, 64'(base));
  endtask

  // mostly images carrying the pattern, some near misses built from pattern bytes, some noise
  task automatic send_random_image(output int unsigned count);
    int unsigned len;
    int unsigned n;
    int unsigned at;
    int unsigned style;
    int unsigned k;
    logic [7:0]  b;
    len   = active_length();
    n     = $urandom_range(3 * len + 8, 1);
    style = $urandom_range(99);
    at    = (n >= len) ? $urandom_range(n - len, 0) : 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (style < 70 && n >= len && i >= at && i < at + len) begin
        k = i - at;
        b = cfg.wildcard_mask[k] ? 8'($urandom) : pattern_byte(k);
      end else if (style < 90 && $urandom_range(1)) begin
        b = pattern_byte($urandom_range(len - 1, 0));
      end else begin
        b = 8'($urandom);
      end
      send_byte(b, i == n - 1);
    end
    count = n;
  endtask

  task automatic test_reset_defaults();
    send_byte(8'h01, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    drain_results();
  endtask

  task automatic test_bytes_after_match();
    write_register(REG_PATTERN_FIRST_EIGHT, 64'hAB);
    write_register(REG_IMAGE_BASE, 64'h1000);
    send_byte(8'hAB, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);
    drain_results();
  endtask

  task automatic test_full_length_last_byte();
    write_register(REG_PATTERN_FIRST_EIGHT, 64'h0123_4567_89AB_CDEF);
    write_register(REG_PATTERN_LAST_EIGHT, 64'hFFEE_DDCC_BBAA_9988);
    write_register(REG_WILDCARD_MASK, 64'h8001);
    write_register(REG_PATTERN_LENGTH, 64'd16);
    write_register(REG_IMAGE_BASE, 64'hFFFF_FFFF_FFFF);
    send_byte(8'h00, 1'b0);
    for (int unsigned k = 0; k < MAX_PATTERN_BYTES; k++)
      send_byte(cfg.wildcard_mask[k] ? 8'($urandom) : pattern_byte(k),
                k == MAX_PATTERN_BYTES - 1);
    drain_results();
  endtask

  task automatic test_length_clamping();
    write_register(REG_PATTERN_LENGTH, 64'd0);
    write_register(REG_WILDCARD_MASK, 64'h0);
    send_byte(8'hEF, 1'b1);
    drain_results();
    write_register(REG_PATTERN_LENGTH, 64'd31);
    write_register(REG_WILDCARD_MASK, 64'hFFFF);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b1);
    drain_results();
  endtask

  task automatic test_midscan_config();
    write_register(REG_WILDCARD_MASK, 64'h0);
    write_register(REG_PATTERN_FIRST_EIGHT, 64'h5A);
    write_register(REG_PATTERN_LENGTH, 64'd1);
    send_byte(8'h3C, 1'b0);
    drain_results();
    write_register(REG_PATTERN_FIRST_EIGHT, 64'h5A3C);
    write_register(REG_PATTERN_LENGTH, 64'd2);
    send_byte(8'h5A, 1'b1);
    drain_results();
  endtask

  task automatic test_random_phase(input int src_pct, input int sink_pct, input logic hold_off);
    int unsigned sent;
    int unsigned n;
    int unsigned images;
    drain_results();
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    randomise_config();
    if (hold_off) hold_req = 1'b1;
    sent   = 0;
    images = 0;
    while (sent < RANDOM_ITEMS_PER_PHASE) begin
      send_random_image(n);
      sent += n;
      images++;
      if (images % 6 == 0) begin
        drain_results();
        randomise_config();
      end
    end
    drain_results();
  endtask

  initial begin
    cfg = '0;
    cfg.pattern_length = LEN_BITS'(1);
    clear_scan();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_bytes_after_match();
    test_full_length_last_byte();
    test_length_clamping();
    test_midscan_config();
    test_random_phase(0, 0, 1'b1);
    test_random_phase(58, 0, 1'b0);
    test_random_phase(0, 58, 1'b0);
    test_random_phase(24, 24, 1'b0);
    drain_results();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/wbps_pkg.sv
design/wbps_cfg_regs.sv
design/wbps_match.sv
design/wbps_result.sv
design/wildcard_byte_pattern_scanner.sv
design/wbps_checker.sv
tb/sv/tb.sv
